@@ rtl/gafv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register indexes, sequencer states and a ceil_sqrt helper for the grid viewport block.
package gafv_pkg;

  localparam int MAX_SLOTS_DEFAULT = 64;
  localparam int DIM_BITS_DEFAULT  = 13;

  localparam int SLOT_BITS      = 6;
  localparam int COUNT_REG_BITS = 7;
  localparam int CFG_INDEX_BITS = 2;

  localparam int RESET_SURFACE_WIDTH  = 1920;
  localparam int RESET_SURFACE_HEIGHT = 1080;
  localparam int RESET_TILE_COUNT     = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_COUNT     = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ROWS = 9'b000000010,
    ST_PW   = 9'b000000100,
    ST_PH   = 9'b000001000,
    ST_SLOT = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_CMP  = 9'b001000000,
    ST_FIT  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  function automatic int ceil_sqrt(input int n);
    int r;
    r = 1;
    while (r * r < n) r++;
    return r;
  endfunction

endpackage

@@ rtl/grid_aspect_fit_viewport_top.sv @@
`timescale 1ns / 1ps
// Top level: grid tile viewport with aspect-kept fit, sequencer around a serial divider.
//
// One item at a time: five divisions run on a single bit-serial divider (one quotient bit
// per cycle), and the next item can be taken in the cycle after the result is registered.
// A zero source dimension skips the fit division. The result register frees the input
// side while a finished result waits to be taken.
module grid_aspect_fit_viewport_top #(
  parameter int MAX_SLOTS = gafv_pkg::MAX_SLOTS_DEFAULT,
  parameter int DIM_BITS  = gafv_pkg::DIM_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // slot_number, source_width, source_height (lowest bit first), zero padded
  input  logic [((gafv_pkg::SLOT_BITS + 2 * DIM_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // view_x, view_y, view_width, view_height (lowest bit first), zero padded
  output logic [((4 * DIM_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [gafv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data
);

  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int NUM_W    = CNT_W + 1;
  localparam int COLS_MAX = gafv_pkg::ceil_sqrt(MAX_SLOTS);
  localparam int COL_W    = $clog2(COLS_MAX + 1);
  localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DW       = (DIM_BITS > NUM_W) ? DIM_BITS : NUM_W;
  localparam int BW       = $clog2(DW + 1);
  localparam int POS_W    = DIM_BITS + 1;
  localparam int PROD_W   = 2 * DIM_BITS;
  localparam int OUT_W    = ((4 * DIM_BITS + 2 + 7) / 8) * 8;
  localparam int SB       = gafv_pkg::SLOT_BITS;

  logic [DIM_BITS-1:0]                 surface_width;
  logic [DIM_BITS-1:0]                 surface_height;
  logic [gafv_pkg::COUNT_REG_BITS-1:0] tile_count;

  gafv_pkg::state_t state;

  logic [SB-1:0]       in_slot;
  logic [DIM_BITS-1:0] in_sw;
  logic [DIM_BITS-1:0] in_sh;
  logic [CNT_W-1:0]    count_c;
  logic [COL_W-1:0]    cols_c;
  logic [SLOT_W-1:0]   slot_c;
  logic [NUM_W-1:0]    rows_num_c;

  logic              div_start;
  logic              div_start_next;
  logic [DW-1:0]     div_hi;
  logic [DW-1:0]     div_lo;
  logic [DW-1:0]     div_den;
  logic [BW-1:0]     div_bits;
  logic              div_done;
  logic [DW-1:0]     div_quo;
  logic [DW-1:0]     div_rem;

  logic [COL_W-1:0]    cols_r;
  logic [COL_W-1:0]    rows_r;
  logic [COL_W-1:0]    col_r;
  logic [COL_W-1:0]    row_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [DIM_BITS-1:0] src_w;
  logic [DIM_BITS-1:0] src_h;
  logic [DIM_BITS-1:0] pw;
  logic [DIM_BITS-1:0] ph;
  logic [DIM_BITS-1:0] fw;
  logic [DIM_BITS-1:0] fh;
  logic [PROD_W-1:0]   prod_a;
  logic [PROD_W-1:0]   prod_b;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [POS_W-1:0]    phr;
  logic                empty;
  logic                wide;

  logic [DIM_BITS-1:0] off_x;
  logic [DIM_BITS-1:0] off_y;
  logic [POS_W-1:0]    view_x_next;
  logic [POS_W-1:0]    view_y_next;
  logic [DIM_BITS-1:0] view_width_next;
  logic [DIM_BITS-1:0] view_height_next;

  logic                out_valid;
  logic                out_load;
  logic [POS_W-1:0]    view_x;
  logic [POS_W-1:0]    view_y;
  logic [DIM_BITS-1:0] view_width;
  logic [DIM_BITS-1:0] view_height;

  assign in_slot = s_axis_tdata[SB-1:0];
  assign in_sw   = s_axis_tdata[SB +: DIM_BITS];
  assign in_sh   = s_axis_tdata[SB + DIM_BITS +: DIM_BITS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= DIM_BITS'(gafv_pkg::RESET_SURFACE_WIDTH);
      surface_height <= DIM_BITS'(gafv_pkg::RESET_SURFACE_HEIGHT);
      tile_count     <= gafv_pkg::COUNT_REG_BITS'(gafv_pkg::RESET_TILE_COUNT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gafv_pkg::REG_SURFACE_WIDTH: begin
          surface_width <= cfg_data;
        end
        gafv_pkg::REG_SURFACE_HEIGHT: begin
          surface_height <= cfg_data;
        end
        gafv_pkg::REG_TILE_COUNT: begin
          tile_count <= cfg_data[gafv_pkg::COUNT_REG_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (tile_count == '0) begin
      count_c = CNT_W'(1);
    end else if (int'(tile_count) > MAX_SLOTS) begin
      count_c = CNT_W'(MAX_SLOTS);
    end else begin
      count_c = CNT_W'(tile_count);
    end
  end

  always_comb begin
    cols_c = COL_W'(COLS_MAX);
    for (int i = COLS_MAX; i >= 1; i--) begin
      if (i * i >= int'(count_c)) cols_c = COL_W'(i);
    end
  end

  always_comb begin
    if (int'(in_slot) > int'(count_c) - 1) begin
      slot_c = SLOT_W'(count_c - 1'b1);
    end else begin
      slot_c = SLOT_W'(in_slot);
    end
  end

  assign rows_num_c = NUM_W'(count_c) + NUM_W'(cols_c) - 1'b1;

  gafv_div #(
    .W(DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_hi(div_hi),
    .num_lo(div_lo),
    .den   (div_den),
    .bits  (div_bits),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign s_axis_tready = (state == gafv_pkg::ST_IDLE);

  assign off_x       = (pw - fw) >> 1;
  assign off_y       = (ph - fh) >> 1;
  assign view_x_next = pos_x + POS_W'(off_x);
  assign view_y_next = pos_y + POS_W'(off_y);

  always_comb begin
    if (empty) begin
      view_width_next  = '0;
      view_height_next = '0;
    end else begin
      view_width_next  = (fw == '0) ? DIM_BITS'(1) : fw;
      view_height_next = (fh == '0) ? DIM_BITS'(1) : fh;
    end
  end

  assign div_start_next =
    ((state == gafv_pkg::ST_IDLE) && s_axis_tvalid) ||
    ((state inside {gafv_pkg::ST_ROWS, gafv_pkg::ST_PW, gafv_pkg::ST_PH}) && div_done) ||
    ((state == gafv_pkg::ST_CMP) && (src_w != '0) && (src_h != '0));

  assign out_load = (state == gafv_pkg::ST_FIN) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= div_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gafv_pkg::ST_IDLE;
    end else begin
      case (state)
        gafv_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            cols_r    <= cols_c;
            slot_r    <= slot_c;
            src_w     <= in_sw;
            src_h     <= in_sh;
            div_hi    <= '0;
            div_lo    <= DW'(rows_num_c);
            div_den   <= DW'(cols_c);
            div_bits  <= BW'(NUM_W);
            state     <= gafv_pkg::ST_ROWS;
          end
        end
        gafv_pkg::ST_ROWS: begin
          if (div_done) begin
            rows_r    <= COL_W'(div_quo);
            div_hi    <= '0;
            div_lo    <= DW'(surface_width);
            div_den   <= DW'(cols_r);
            div_bits  <= BW'(DIM_BITS);
            state     <= gafv_pkg::ST_PW;
          end
        end
        gafv_pkg::ST_PW: begin
          if (div_done) begin
            pw        <= (div_quo[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : div_quo[DIM_BITS-1:0];
            div_hi    <= '0;
            div_lo    <= DW'(surface_height);
            div_den   <= DW'(rows_r);
            div_bits  <= BW'(DIM_BITS);
            state     <= gafv_pkg::ST_PH;
          end
        end
        gafv_pkg::ST_PH: begin
          if (div_done) begin
            ph        <= (div_quo[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : div_quo[DIM_BITS-1:0];
            div_hi    <= '0;
            div_lo    <= DW'(slot_r);
            div_den   <= DW'(cols_r);
            div_bits  <= BW'(SLOT_W);
            state     <= gafv_pkg::ST_SLOT;
          end
        end
        gafv_pkg::ST_SLOT: begin
          if (div_done) begin
            col_r <= COL_W'(div_rem);
            row_r <= COL_W'(div_quo);
            state <= gafv_pkg::ST_MUL;
          end
        end
        gafv_pkg::ST_MUL: begin
          prod_a <= PROD_W'(pw) * PROD_W'(src_h);
          prod_b <= PROD_W'(src_w) * PROD_W'(ph);
          pos_x  <= POS_W'(pw) * POS_W'(col_r);
          phr    <= POS_W'(ph) * POS_W'(row_r + 1'b1);
          state  <= gafv_pkg::ST_CMP;
        end
        gafv_pkg::ST_CMP: begin
          pos_y <= POS_W'(surface_height) - phr;
          fw    <= pw;
          fh    <= ph;
          if (src_w == '0 || src_h == '0) begin
            empty <= 1'b1;
            state <= gafv_pkg::ST_FIN;
          end else begin
            empty     <= 1'b0;
            div_bits  <= BW'(DIM_BITS);
            if (prod_a > prod_b) begin
              wide    <= 1'b1;
              div_hi  <= DW'(prod_b[PROD_W-1:DIM_BITS]);
              div_lo  <= DW'(prod_b[DIM_BITS-1:0]);
              div_den <= DW'(src_h);
            end else begin
              wide    <= 1'b0;
              div_hi  <= DW'(prod_a[PROD_W-1:DIM_BITS]);
              div_lo  <= DW'(prod_a[DIM_BITS-1:0]);
              div_den <= DW'(src_w);
            end
            state <= gafv_pkg::ST_FIT;
          end
        end
        gafv_pkg::ST_FIT: begin
          if (div_done) begin
            if (wide) begin
              fw <= div_quo[DIM_BITS-1:0];
            end else begin
              fh <= div_quo[DIM_BITS-1:0];
            end
            state <= gafv_pkg::ST_FIN;
          end
        end
        gafv_pkg::ST_FIN: begin
          if (out_load) begin
            view_x      <= view_x_next;
            view_y      <= view_y_next;
            view_width  <= view_width_next;
            view_height <= view_height_next;
            state       <= gafv_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= gafv_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({view_height, view_width, view_y, view_x});

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == gafv_pkg::ST_ROWS && div_start))
    else $error("accepted item did not start the row division");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == gafv_pkg::ST_ROWS || state == gafv_pkg::ST_PW ||
                  state == gafv_pkg::ST_PH || state == gafv_pkg::ST_SLOT ||
                  state == gafv_pkg::ST_FIT))
    else $error("divider finished outside a division wait state");

  a_size_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((view_width == '0) == (view_height == '0)))
    else $error("only one viewport dimension is zero");

endmodule

@@ rtl/gafv_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, high half below the divisor.
module gafv_div #(
  parameter int W = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [W-1:0]           num_hi,
  input  logic [W-1:0]           num_lo,
  input  logic [W-1:0]           den,
  input  logic [$clog2(W+1)-1:0] bits,
  output logic                   done,
  output logic [W-1:0]           quo,
  output logic [W-1:0]           rem
);

  localparam int BW = $clog2(W + 1);

  logic          busy;
  logic [BW-1:0] cnt;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  den_q;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == BW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= num_hi;
      quo_q <= num_lo << (BW'(W) - bits);
      den_q <= den;
    end else if (busy) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign quo = quo_q;
  assign rem = rem_q;

endmodule
